// ===== sv/stfg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and fixed constants for the sine tone frame generator.
// No dependencies; imported by sine_tone_frame_generator, stfg_checker and tb.

package stfg_pkg;

    // Field widths fixed by the stream and register formats
    localparam int FREQ_W      = 12;
    localparam int SAMPLE_W    = 16;
    localparam int OUT_INDEX_W = 8;
    localparam int MAG_W       = 15;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    // Sine scaling and series evaluation constants
    localparam logic [MAG_W-1:0] FULL_SCALE   = 15'h7FFF;
    localparam logic [63:0]      HALF_PI_Q62  = 64'h6487ED5110B4611A;
    localparam int               SERIES_TERMS = 12;

    // Tone frequency after reset, in hertz
    localparam int FREQ_RESET = 1000;

    // Fraction bits of the reciprocal used to reduce the frequency
    localparam int RECIP_SHIFT = 24;

    // Fields that travel with a sample between table read and output
    typedef struct packed {
        logic                   neg;
        logic [OUT_INDEX_W-1:0] sample_index;
        logic                   frame_last;
    } sample_tag_t;

endpackage

// ===== sv/sine_tone_frame_generator.sv =====
`timescale 1ns / 1ps
// Sine tone frame generator: phase accumulator and quarter-wave sine table.
// Depends on stfg_pkg for field widths, constants and the sample tag type.
//
//  channel   dir  handshake                  payload
//  s_*       in   s_tvalid / s_tready        s_tdata[0] restart
//  m_*       out  m_tvalid / m_tready        m_tdata: sample, sample_index; m_tlast
//  cfg_*     in   cfg_wr_en (no wait)        cfg_wr_data tone_frequency
//
// One sample per cycle sustained while no m_tready stall or configuration write
// holds it; an input passes the table read register, then the output register.
// The rate is set by the phase add with one conditional subtract feeding the
// synchronous table ROM. Reset clears the index, the phase and the pipeline
// valids and loads the step for 1000 Hz. A configuration write holds s_tready low
// while the new phase step is reduced. The table stage takes one more input while
// a finished sample waits on a stalled m_tready; then s_tready drops until it moves.

module sine_tone_frame_generator
    import stfg_pkg::*;
#(
    parameter int FRAME_LENGTH = 256,
    parameter int SAMPLE_RATE  = 8000
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // [0] restart, [7:1] zero

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,      // [15:0] sample, [23:16] sample_index
    output logic                 m_tlast,      // frame_last

    input  logic                 cfg_wr_en,
    input  logic [FREQ_W-1:0]    cfg_wr_data   // tone_frequency
);

    // Derived sizes
    localparam int IW        = (FRAME_LENGTH > 2) ? $clog2(FRAME_LENGTH) : 1;
    localparam int PW        = $clog2(SAMPLE_RATE);
    localparam int SW        = PW + 1;
    localparam int UW        = PW + 3;
    localparam int ADDR_SHIFT = (SAMPLE_RATE % 2 == 0) ? 2 : 1;
    localparam int ROM_DEPTH = (SAMPLE_RATE >> ADDR_SHIFT) + 1;
    localparam int AW        = $clog2(ROM_DEPTH);
    localparam int PROD_W    = FREQ_W + RECIP_SHIFT;
    localparam int REM_W     = FREQ_W + 18;

    localparam logic [IW-1:0]          LAST_INDEX = IW'(FRAME_LENGTH - 1);
    localparam logic [SW-1:0]          SR_S       = SW'(SAMPLE_RATE);
    localparam logic [UW-1:0]          SR_U       = UW'(SAMPLE_RATE);
    localparam logic [UW-1:0]          TWO_SR_U   = UW'(2 * SAMPLE_RATE);
    localparam logic [PW-1:0]          STEP_RESET = PW'(FREQ_RESET % SAMPLE_RATE);
    localparam logic [RECIP_SHIFT-1:0] RECIP      = RECIP_SHIFT'((1 << RECIP_SHIFT) / SAMPLE_RATE);
    localparam logic [63:0]            HP_DIV     = HALF_PI_Q62 / SAMPLE_RATE;
    localparam logic [63:0]            HP_MOD     = HALF_PI_Q62 % SAMPLE_RATE;

    // ------------------------------------------------------------------
    // Elaboration-time table builder: exactly truncated sine magnitudes
    // ------------------------------------------------------------------

    // (a * b) >> 62, kept to 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // One series term: previous term times x^2 over (2k)(2k+1)
    function automatic logic [63:0] next_term(input logic [63:0] p, input int k);
        logic [63:0] t;
        case (k)
            1:       t = p / 6;
            2:       t = p / 20;
            3:       t = p / 42;
            4:       t = p / 72;
            5:       t = p / 110;
            6:       t = p / 156;
            7:       t = p / 210;
            8:       t = p / 272;
            9:       t = p / 342;
            10:      t = p / 420;
            11:      t = p / 506;
            12:      t = p / 600;
            default: t = '0;
        endcase
        return t;
    endfunction

    // Magnitude for table entry a; the angle in quarter turns is (a << shift) / rate
    function automatic logic [MAG_W-1:0] sine_mag(input int a);
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] mag;
        u = 64'(a) << ADDR_SHIFT;
        if (u == 64'd0)
        begin
            return '0;
        end
        if (u >= 64'(SAMPLE_RATE))
        begin
            return FULL_SCALE;
        end
        x    = HP_DIV * u + (HP_MOD * u) / SAMPLE_RATE;
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k <= SERIES_TERMS; k++)
        begin
            term = next_term(mul_q62(term, x2), k);
            if (k % 2 == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        hi  = sum >> 31;
        lo  = sum & 64'h7FFF_FFFF;
        mag = (hi * 64'(FULL_SCALE) + ((lo * 64'(FULL_SCALE)) >> 31)) >> 31;
        if (mag > 64'(FULL_SCALE))
        begin
            mag = 64'(FULL_SCALE);
        end
        return mag[MAG_W-1:0];
    endfunction

    // Quarter-wave ROM contents
    logic [MAG_W-1:0] rom_table [ROM_DEPTH];

    for (genvar g = 0; g < ROM_DEPTH; g++)
    begin : g_rom
        localparam logic [MAG_W-1:0] ENTRY = sine_mag(g);
        assign rom_table[g] = ENTRY;
    end

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic              accept;
    logic              s1_move;
    logic              out_move;
    logic              restart;

    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     idx_next;
    logic [IW-1:0]     idx_cur;
    logic [PW-1:0]     phase_reg;
    logic [PW-1:0]     phase_next;
    logic [PW-1:0]     phase_cur;
    logic [SW-1:0]     phase_sum;
    logic              is_last;

    logic [UW-1:0]     u_full;
    logic [UW-1:0]     u_half;
    logic [UW-1:0]     u_quad;
    logic              fold_neg;
    logic [AW-1:0]     rom_addr;
    logic              rom_neg;

    logic [PW-1:0]     step_reg;
    logic [1:0]        cfg_pend_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [FREQ_W-1:0] quot_reg;
    logic [SW-1:0]     rem_reg;
    logic [PROD_W-1:0] recip_prod;
    logic [REM_W-1:0]  rem_full;

    logic              s1_valid_reg;
    sample_tag_t       s1_tag_reg;
    logic [MAG_W-1:0]  s1_mag_reg;

    logic              m_valid_reg;
    logic [SAMPLE_W-1:0]    m_sample_reg;
    logic [OUT_INDEX_W-1:0] m_index_reg;
    logic              m_last_reg;
    logic [SAMPLE_W-1:0]    sample_signed;

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    assign out_move = !m_valid_reg || m_tready;
    assign s1_move  = !s1_valid_reg || out_move;
    assign s_tready = s1_move && (cfg_pend_reg == 2'b00);
    assign accept   = s_tvalid && s_tready;
    assign restart  = s_tdata[0];

    // ------------------------------------------------------------------
    // Frequency to phase step: reciprocal estimate, remainder, correction
    // ------------------------------------------------------------------
    assign recip_prod = PROD_W'(cfg_wr_data) * PROD_W'(RECIP);
    assign rem_full   = REM_W'(freq_reg) - REM_W'(quot_reg) * REM_W'(SAMPLE_RATE);

    always_ff @(posedge clk)
    begin
        if (cfg_wr_en)
        begin
            freq_reg <= cfg_wr_data;
            quot_reg <= recip_prod[PROD_W-1:RECIP_SHIFT];
        end
        if (cfg_pend_reg[0])
        begin
            rem_reg <= rem_full[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_pend_reg <= 2'b00;
            step_reg     <= STEP_RESET;
        end
        else
        begin
            cfg_pend_reg <= {cfg_pend_reg[0], cfg_wr_en};
            if (cfg_pend_reg[1])
            begin
                if (rem_reg >= SR_S)
                begin
                    step_reg <= PW'(rem_reg - SR_S);
                end
                else
                begin
                    step_reg <= rem_reg[PW-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Index and phase for this transaction, and their next values
    // ------------------------------------------------------------------
    always_comb
    begin
        idx_cur   = restart ? '0 : idx_reg;
        phase_cur = restart ? '0 : phase_reg;
        is_last   = (idx_cur == LAST_INDEX);
        phase_sum = {1'b0, phase_cur} + {1'b0, step_reg};
        if (is_last)
        begin
            idx_next   = '0;
            phase_next = '0;
        end
        else
        begin
            idx_next = idx_cur + 1'b1;
            if (phase_sum >= SR_S)
            begin
                phase_next = PW'(phase_sum - SR_S);
            end
            else
            begin
                phase_next = phase_sum[PW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            phase_reg <= '0;
        end
        else if (accept)
        begin
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    // ------------------------------------------------------------------
    // Fold the stored phase into the first quadrant (restart maps to zero)
    // ------------------------------------------------------------------
    always_comb
    begin
        u_full   = {1'b0, phase_reg, 2'b00};
        fold_neg = (u_full >= TWO_SR_U);
        u_half   = fold_neg ? (u_full - TWO_SR_U) : u_full;
        u_quad   = (u_half > SR_U) ? (TWO_SR_U - u_half) : u_half;
        rom_addr = restart ? '0 : AW'(u_quad >> ADDR_SHIFT);
        rom_neg  = restart ? 1'b0 : fold_neg;
    end

    // ------------------------------------------------------------------
    // Table read stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s1_mag_reg              <= rom_table[rom_addr];
            s1_tag_reg.neg          <= rom_neg;
            s1_tag_reg.sample_index <= OUT_INDEX_W'(idx_cur);
            s1_tag_reg.frame_last   <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= accept;
        end
    end

    // ------------------------------------------------------------------
    // Output register: apply the sign
    // ------------------------------------------------------------------
    assign sample_signed = s1_tag_reg.neg ? (SAMPLE_W'(0) - SAMPLE_W'(s1_mag_reg))
                                          : SAMPLE_W'(s1_mag_reg);

    always_ff @(posedge clk)
    begin
        if (out_move)
        begin
            m_sample_reg <= sample_signed;
            m_index_reg  <= s1_tag_reg.sample_index;
            m_last_reg   <= s1_tag_reg.frame_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_move)
        begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_index_reg, m_sample_reg};
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SW'(phase_reg) < SR_S) && (SW'(step_reg) < SR_S))
        else $error("phase or step out of range");

    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !s_tready ##1 !s_tready)
        else $error("input taken while phase step is updating");

    a_restart_index: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart) |=> (s1_valid_reg && s1_tag_reg.sample_index == '0
                                  && !s1_tag_reg.neg && s1_mag_reg == '0))
        else $error("restart did not start at index and phase zero");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_last_reg) |-> (m_index_reg == OUT_INDEX_W'(FRAME_LENGTH - 1)))
        else $error("frame end on wrong index");

endmodule

// ===== test/stfg_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sine tone frame generator: follows the frequency register,
// predicts one sample per input transaction and compares every output transaction.
// Depends on stfg_pkg for the stream widths and the sine scaling constants.

module stfg_checker
    import stfg_pkg::*;
#(
    parameter int FRAME_LENGTH = 256,
    parameter int SAMPLE_RATE  = 8000
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // [0] restart, [7:1] zero

    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,      // [15:0] sample, [23:16] sample_index
    input  logic                 m_tlast,      // frame_last

    input  logic                 cfg_wr_en,
    input  logic [FREQ_W-1:0]    cfg_wr_data,  // tone_frequency

    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [OUT_INDEX_W-1:0]     sample_index;
        logic                       frame_last;
    } tone_sample_t;

    tone_sample_t      expected_samples[$];
    logic [FREQ_W-1:0] freq_hz;
    int                frame_pos;
    int                phase;
    int                errors;

    // (a * b) >> 62, low 64 bits kept
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // Exactly truncated sin(2*pi*p/rate) * full scale, by quadrant fold and series
    function automatic logic signed [SAMPLE_W-1:0] sine_of_phase(input int p);
        logic [63:0] rate;
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] mag;
        logic        neg;
        rate = 64'(SAMPLE_RATE);
        u    = 64'(p) * 64'd4;
        neg  = 1'b0;
        if (u >= 2 * rate)
        begin
            neg = 1'b1;
            u   = u - 2 * rate;
        end
        if (u > rate)
            u = 2 * rate - u;
        if (u == 64'd0)
            return '0;
        if (u == rate)
            return neg ? -16'sd32767 : 16'sd32767;
        x    = (HALF_PI_Q62 / rate) * u + ((HALF_PI_Q62 % rate) * u) / rate;
        x2   = q62_mul(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k <= SERIES_TERMS; k++)
        begin
            term = q62_mul(term, x2) / (64'(2 * k) * 64'(2 * k + 1));
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        hi  = sum >> 31;
        lo  = sum & 64'h7FFF_FFFF;
        mag = (hi * 64'(FULL_SCALE) + ((lo * 64'(FULL_SCALE)) >> 31)) >> 31;
        if (mag > 64'(FULL_SCALE))
            mag = 64'(FULL_SCALE);
        return neg ? -$signed(mag[SAMPLE_W-1:0]) : $signed(mag[SAMPLE_W-1:0]);
    endfunction

    // Compare outputs, then predict from inputs, then track register writes
    always @(posedge clk or negedge rst_n)
    begin
        tone_sample_t got;
        tone_sample_t want;
        if (!rst_n)
        begin
            freq_hz    <= FREQ_W'(FREQ_RESET);
            frame_pos   = 0;
            phase       = 0;
            errors      = 0;
            expected_samples.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.sample       = m_tdata[15:0];
                got.sample_index = m_tdata[23:16];
                got.frame_last   = m_tlast;
                if (expected_samples.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected output transaction: sample %0d index %0d last %0b",
                                 $signed(got.sample), got.sample_index, got.frame_last);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected sample %0d index %0d last %0b, %s %0d %0d %0b",
                                     $signed(want.sample), want.sample_index, want.frame_last,
                                     "got", $signed(got.sample), got.sample_index,
                                     got.frame_last);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tdata[0])
                begin
                    frame_pos = 0;
                    phase     = 0;
                end
                want.sample       = sine_of_phase(phase);
                want.sample_index = frame_pos[OUT_INDEX_W-1:0];
                want.frame_last   = (frame_pos == FRAME_LENGTH - 1);
                expected_samples.push_back(want);
                if (want.frame_last)
                begin
                    frame_pos = 0;
                    phase     = 0;
                end
                else
                begin
                    frame_pos++;
                    phase += int'(freq_hz) % SAMPLE_RATE;
                    if (phase >= SAMPLE_RATE)
                        phase -= SAMPLE_RATE;
                end
            end

            if (cfg_wr_en)
                freq_hz <= cfg_wr_data;

            fail_count <= errors;
            pending    <= expected_samples.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Top of the sine tone frame generator bench: clock, reset, tick and register
// stimulus, output back-pressure and the verdict.
// Depends on stfg_pkg, sine_tone_frame_generator and stfg_checker.

module tb;
    import stfg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;      // [0] restart, [7:1] zero
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;      // [15:0] sample, [23:16] sample_index
    logic                 m_tlast;      // frame_last
    logic                 cfg_wr_en;
    logic [FREQ_W-1:0]    cfg_wr_data;  // tone_frequency

    int fail_count;
    int pending;
    int cycle_count    = 0;
    int stall_left     = 0;
    bit sender_idles   = 1'b0;
    bit receiver_idles = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    sine_tone_frame_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    stfg_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Receiver back-pressure: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (receiver_idles && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // One tick transaction, then maybe an idle burst
    task automatic send_tick(input bit restart);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, restart};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_ticks(input int count, input int restart_odds);
        for (int i = 0; i < count; i++)
            send_tick(restart_odds > 0 && $urandom_range(1, restart_odds) == 1);
    endtask

    // Stop sending and wait for every predicted sample to come out
    task automatic drain();
        if (s_tvalid)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_frequency(input logic [FREQ_W-1:0] hz);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hz;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        rst_n       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset frequency, restart, quadrant ends, zero and extreme steps
        repeat (3) send_tick(1'b0);
        send_tick(1'b1);
        write_frequency(12'd2000);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        write_frequency(12'd0);
        repeat (3) send_tick(1'b0);
        write_frequency(12'hFFF);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        write_frequency(12'd1);
        repeat (2) send_tick(1'b0);
        write_frequency(12'd3999);
        repeat (3) send_tick(1'b0);

        // Random phases, each with its own frequency and idling mix
        for (int p = 0; p < 4; p++)
        begin
            if (p == 1)
                write_frequency(12'hFFF);
            else if (p == 3)
                write_frequency(12'd1);
            else
                write_frequency(FREQ_W'($urandom_range(0, 4095)));
            sender_idles   = ($urandom_range(0, 2) != 0);
            receiver_idles = ($urandom_range(0, 2) != 0);
            run_ticks($urandom_range(20, 40), 12);
        end

        // A full frame and its wrap, with a mid-frame pause for all results
        write_frequency(FREQ_W'($urandom_range(1, 3999)));
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        send_tick(1'b1);
        run_ticks(130, 0);
        drain();
        run_ticks(140, 0);

        // Tail without idling
        write_frequency(FREQ_W'($urandom_range(0, 4095)));
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        run_ticks(30, 10);

        if (s_tvalid)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sine_tone_frame_generator.f =====
sv/stfg_pkg.sv
sv/sine_tone_frame_generator.sv
test/stfg_checker.sv
test/tb.sv
